[rtl/assert_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that post holds in the cycle after pre, outside of reset.
`define PIDFD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// Checks that post holds in the cycle after pre, including the reset cycles.
`define PIDFD_ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/pidfd_pkg.sv]
`default_nettype none

package pidfd_pkg;

    // Default sample width (Q.12 samples).
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int EL_W       = 20;
    localparam int LIM_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int ALPHA_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Shared multiplier: the second operand is 18 bits signed, and the
    // wide integral product is cut into 17 bit chunks.
    localparam int MB_W    = 18;
    localparam int CHUNK_W = 17;
    localparam int CPROD_W = EL_W + CHUNK_W;

    // 256000000 = 2^14 * 15625: shift by 14, then divide by 15625.
    localparam int          TIME_SHIFT = 14;
    localparam int          REM_W      = 14;
    localparam logic [14:0] DIV_ODD    = 15'd15625;
    localparam int          DIV_BITS   = 4;

    // Rounding constants for the gain and filter shifts.
    localparam int GAIN_FRAC  = 8;
    localparam int GAIN_HALF  = 128;
    localparam int ALPHA_FRAC = 16;
    localparam int ALPHA_HALF = 32768;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    // Register reset values.
    localparam logic [ALPHA_W-1:0]      ALPHA_RST   = 17'h10000;
    localparam logic signed [LIM_W-1:0] OUT_MAX_RST = 16'sd4096;
    localparam logic signed [LIM_W-1:0] OUT_MIN_RST = -16'sd4096;

    // Input word actions.
    localparam logic ACT_COMPUTE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_ALPHA   = 3'd3,
        CFG_OUT_MAX = 3'd4,
        CFG_OUT_MIN = 3'd5,
        CFG_INT_EN  = 3'd6
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PROP,
        S_IMUL,
        S_RAW,
        S_FPREV,
        S_FSUM,
        S_DMUL,
        S_DRND,
        S_CMUL,
        S_CACC,
        S_DIV,
        S_ISUM,
        S_ICLAMP,
        S_YSUM,
        S_YCLAMP
    } t_state;

endpackage

`default_nettype wire

[rtl/pid_filtered_derivative_top.sv]
`default_nettype none

// PID step with derivative on measurement and a low-pass filtered derivative.
// Input channel: i_valid/o_ready carry one word (action plus samples). An
// action of compute runs one control step and yields one output word; an
// action of clear zeroes the integrator and the filter and yields nothing.
// Output channel: o_valid/i_ready carry the clamped control output.
// Configuration: i_cfg_valid/o_cfg_ready write i_cfg_data to register
// i_cfg_index; the port is always ready, and writes belong to idle periods.
// All products go through one shared 18-bit-operand multiplier, and the
// integral increment goes through a divider that retires 4 quotient bits
// per cycle; a small sequencer steps them one word at a time.
// A compute word steps through PROP, IMUL, RAW, FPREV, FSUM, DMUL, DRND,
// then CMUL and CACC once per 17-bit chunk, DIV, ISUM, ICLAMP, YSUM and
// YCLAMP; when lock_integral is set, DRND goes straight to ISUM.
// o_ready returns with o_valid, so a new word waits until the last one is
// done; a clear word leaves the block ready. The output register holds a
// finished word while the receiver stalls; a new word is still accepted,
// and its result waits in the last step until the register is free.
// Reset loads the register defaults and zeroes all controller state.
module pid_filtered_derivative_top #(
    parameter int SAMPLE_BITS = pidfd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // Configuration write channel
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [pidfd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [pidfd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Input channel
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic                                    i_action,
    input  wire logic signed [SAMPLE_BITS-1:0]           i_measurement,
    input  wire logic signed [SAMPLE_BITS-1:0]           i_setpoint,
    input  wire logic signed [SAMPLE_BITS-1:0]           i_gyro_rate,
    input  wire logic                                    i_use_gyro,
    input  wire logic                                    i_lock_integral,
    input  wire logic [pidfd_pkg::EL_W-1:0]              i_elapsed_us,
    // Output channel
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic signed [SAMPLE_BITS-1:0]                o_control_output
);

    // Derived widths.
    localparam int SB      = SAMPLE_BITS;
    localparam int E_W     = SB + 1;
    localparam int FD_W    = (SB + 1 > 32) ? 32 : SB + 1;
    localparam int MA_W    = (SB + 1 > pidfd_pkg::EL_W + 1) ? SB + 1 : pidfd_pkg::EL_W + 1;
    localparam int MB_W    = pidfd_pkg::MB_W;
    localparam int MP_W    = MA_W + MB_W;
    localparam int CH_W    = pidfd_pkg::CHUNK_W;
    localparam int NCH     = (SB + 16 + CH_W - 1) / CH_W;
    localparam int P1_W    = NCH * CH_W;
    localparam int ACC_W   = SB + 36;
    localparam int DIV_W   = ((ACC_W - pidfd_pkg::TIME_SHIFT + pidfd_pkg::DIV_BITS - 1)
                             / pidfd_pkg::DIV_BITS) * pidfd_pkg::DIV_BITS;
    localparam int DIV_CYC = DIV_W / pidfd_pkg::DIV_BITS;
    localparam int CNT_W   = $clog2(DIV_CYC);
    localparam int IS_W    = DIV_W + 2;
    localparam int Y_W     = SB + 11;
    localparam int REM_W   = pidfd_pkg::REM_W;
    localparam int LIM_W   = pidfd_pkg::LIM_W;
    localparam int GAIN_W  = pidfd_pkg::GAIN_W;
    localparam int ALPHA_W = pidfd_pkg::ALPHA_W;
    localparam int EL_W    = pidfd_pkg::EL_W;
    localparam int AF      = pidfd_pkg::ALPHA_FRAC;

    // Configuration registers.
    logic [GAIN_W-1:0]        r_kp, r_ki, r_kd;
    logic [ALPHA_W-1:0]       r_alpha;
    logic signed [LIM_W-1:0]  r_out_max, r_out_min;
    logic                     r_int_en;

    // Sequencer and controller state.
    pidfd_pkg::t_state        r_state, n_state;
    logic signed [LIM_W-1:0]  r_integ, n_integ;
    logic signed [FD_W-1:0]   r_fd, n_fd;
    logic signed [SB-1:0]     r_last, n_last;
    logic                     r_out_valid, n_out_valid;

    // Working registers.
    logic signed [E_W-1:0]    r_err, n_err, r_raw, n_raw;
    logic [SB-1:0]            r_aerr, n_aerr;
    logic                     r_neg, n_neg, r_lock, n_lock;
    logic [EL_W-1:0]          r_el, n_el;
    logic signed [MP_W-1:0]   r_mul, n_mul;
    logic signed [MP_W:0]     r_facc, n_facc;
    logic signed [Y_W-1:0]    r_pterm, n_pterm, r_dterm, n_dterm, r_ysum, n_ysum;
    logic [P1_W-1:0]          r_prod1, n_prod1;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic [DIV_W-1:0]         r_quo, n_quo;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [IS_W-1:0]   r_isum, n_isum;
    logic signed [SB-1:0]     r_out, n_out;

    // Datapath signals.
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [ALPHA_W-1:0]       alpha_eff, alpha_inv;
    logic signed [MP_W:0]     mul_rnd8;
    logic signed [MP_W+1:0]   filt_sum;
    logic [MP_W+1-AF-FD_W+1:0] filt_top;
    logic signed [FD_W-1:0]   filt_sat;
    logic [ACC_W-1:0]         acc_next;
    logic [DIV_W-1:0]         div_quo;
    logic [REM_W-1:0]         div_rem;
    logic [IS_W-1:0]          quo_ext;
    logic signed [IS_W-1:0]   inc_val, inc_use;
    logic signed [IS_W-1:0]   int_clamped;
    logic signed [Y_W-1:0]    y_clamped;

    // Handshake outputs.
    assign o_cfg_ready      = 1'b1;
    assign o_ready          = (r_state == pidfd_pkg::S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_control_output = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_alpha   <= pidfd_pkg::ALPHA_RST;
            r_out_max <= pidfd_pkg::OUT_MAX_RST;
            r_out_min <= pidfd_pkg::OUT_MIN_RST;
            r_int_en  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pidfd_pkg::CFG_KP:      r_kp      <= i_cfg_data[GAIN_W-1:0];
                pidfd_pkg::CFG_KI:      r_ki      <= i_cfg_data[GAIN_W-1:0];
                pidfd_pkg::CFG_KD:      r_kd      <= i_cfg_data[GAIN_W-1:0];
                pidfd_pkg::CFG_ALPHA:   r_alpha   <= i_cfg_data[ALPHA_W-1:0];
                pidfd_pkg::CFG_OUT_MAX: r_out_max <= signed'(i_cfg_data[LIM_W-1:0]);
                pidfd_pkg::CFG_OUT_MIN: r_out_min <= signed'(i_cfg_data[LIM_W-1:0]);
                pidfd_pkg::CFG_INT_EN:  r_int_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Filter weight, limited to one.
    assign alpha_eff = (r_alpha > pidfd_pkg::ALPHA_ONE) ? pidfd_pkg::ALPHA_ONE : r_alpha;
    assign alpha_inv = pidfd_pkg::ALPHA_ONE - alpha_eff;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            pidfd_pkg::S_PROP: begin
                mul_a = MA_W'(r_err);
                mul_b = MB_W'(r_kp);
            end
            pidfd_pkg::S_IMUL: begin
                mul_a = MA_W'(r_aerr);
                mul_b = MB_W'(r_ki);
            end
            pidfd_pkg::S_RAW: begin
                mul_a = MA_W'(r_raw);
                mul_b = MB_W'(alpha_eff);
            end
            pidfd_pkg::S_FPREV: begin
                mul_a = MA_W'(r_fd);
                mul_b = MB_W'(alpha_inv);
            end
            pidfd_pkg::S_DMUL: begin
                mul_a = MA_W'(r_fd);
                mul_b = MB_W'(r_kd);
            end
            pidfd_pkg::S_CMUL: begin
                mul_a = MA_W'(r_el);
                mul_b = MB_W'(r_prod1[P1_W-1 -: CH_W]);
            end
            default: ;
        endcase
    end

    assign n_mul = mul_a * mul_b;

    // Gain product rounded to nearest, half up, then shifted by 8.
    assign mul_rnd8 = (MP_W+1)'(r_mul) + (MP_W+1)'(pidfd_pkg::GAIN_HALF);

    // Filter sum, rounded shift by 16 and saturation to the state width.
    assign filt_sum = (MP_W+2)'(r_facc) + (MP_W+2)'(r_mul);
    assign filt_top = filt_sum[MP_W+1:AF+FD_W-1];
    always_comb begin
        if ((&filt_top) || !(|filt_top)) begin
            filt_sat = filt_sum[AF+FD_W-1:AF];
        end else begin
            filt_sat = {filt_sum[MP_W+1], {(FD_W-1){~filt_sum[MP_W+1]}}};
        end
    end

    // Chunked product accumulation, most significant chunk first.
    assign acc_next = {r_acc[ACC_W-CH_W-1:0], {CH_W{1'b0}}}
                    + ACC_W'(r_mul[pidfd_pkg::CPROD_W-1:0]);

    // Restoring division by 15625, four quotient bits per cycle.
    always_comb begin : div_step
        logic [REM_W:0]   part;
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        rem = r_rem;
        quo = r_quo;
        part = '0;
        for (int k = 0; k < pidfd_pkg::DIV_BITS; k++) begin
            part = {rem, quo[DIV_W-1]};
            quo  = {quo[DIV_W-2:0], 1'b0};
            if (part >= pidfd_pkg::DIV_ODD) begin
                part   = part - pidfd_pkg::DIV_ODD;
                quo[0] = 1'b1;
            end
            rem = part[REM_W-1:0];
        end
        div_rem = rem;
        div_quo = quo;
    end

    // Signed increment; a locked step adds nothing.
    assign quo_ext = IS_W'(r_quo);
    assign inc_val = r_neg ? signed'(-quo_ext) : signed'(quo_ext);
    assign inc_use = r_lock ? IS_W'(0) : inc_val;

    // Integrator clamp (zero when disabled): upper limit first, then lower limit.
    always_comb begin
        int_clamped = r_int_en ? r_isum : IS_W'(0);
        if (int_clamped > IS_W'(r_out_max)) begin
            int_clamped = IS_W'(r_out_max);
        end
        if (int_clamped < IS_W'(r_out_min)) begin
            int_clamped = IS_W'(r_out_min);
        end
    end

    // Output clamp, same order.
    always_comb begin
        y_clamped = r_ysum;
        if (y_clamped > Y_W'(r_out_max)) begin
            y_clamped = Y_W'(r_out_max);
        end
        if (y_clamped < Y_W'(r_out_min)) begin
            y_clamped = Y_W'(r_out_min);
        end
    end

    // Sequencer: next state and next register values.
    always_comb begin
        n_state     = r_state;
        n_integ     = r_integ;
        n_fd        = r_fd;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_err       = r_err;
        n_raw       = r_raw;
        n_aerr      = r_aerr;
        n_neg       = r_neg;
        n_lock      = r_lock;
        n_el        = r_el;
        n_facc      = r_facc;
        n_pterm     = r_pterm;
        n_dterm     = r_dterm;
        n_ysum      = r_ysum;
        n_prod1     = r_prod1;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_isum      = r_isum;

        // The receiver takes the waiting word.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pidfd_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_action == pidfd_pkg::ACT_CLEAR) begin
                        n_integ = '0;
                        n_fd    = '0;
                    end else begin
                        n_err   = E_W'(i_setpoint) - E_W'(i_measurement);
                        n_raw   = i_use_gyro ? E_W'(i_gyro_rate)
                                             : E_W'(i_measurement) - E_W'(r_last);
                        n_last  = i_measurement;
                        n_lock  = i_lock_integral;
                        n_el    = i_elapsed_us;
                        n_state = pidfd_pkg::S_PROP;
                    end
                end
            end
            pidfd_pkg::S_PROP: begin
                n_neg   = r_err[E_W-1];
                n_aerr  = r_err[E_W-1] ? SB'(-r_err) : SB'(r_err);
                n_state = pidfd_pkg::S_IMUL;
            end
            pidfd_pkg::S_IMUL: begin
                n_pterm = mul_rnd8[pidfd_pkg::GAIN_FRAC +: Y_W];
                n_state = pidfd_pkg::S_RAW;
            end
            pidfd_pkg::S_RAW: begin
                n_prod1 = P1_W'(r_mul[SB+15:0]);
                n_state = pidfd_pkg::S_FPREV;
            end
            pidfd_pkg::S_FPREV: begin
                n_facc  = (MP_W+1)'(r_mul) + (MP_W+1)'(pidfd_pkg::ALPHA_HALF);
                n_state = pidfd_pkg::S_FSUM;
            end
            pidfd_pkg::S_FSUM: begin
                n_fd    = filt_sat;
                n_state = pidfd_pkg::S_DMUL;
            end
            pidfd_pkg::S_DMUL: begin
                n_state = pidfd_pkg::S_DRND;
            end
            pidfd_pkg::S_DRND: begin
                n_dterm = mul_rnd8[pidfd_pkg::GAIN_FRAC +: Y_W];
                n_acc   = '0;
                n_cnt   = CNT_W'(NCH - 1);
                n_state = r_lock ? pidfd_pkg::S_ISUM : pidfd_pkg::S_CMUL;
            end
            pidfd_pkg::S_CMUL: begin
                n_state = pidfd_pkg::S_CACC;
            end
            pidfd_pkg::S_CACC: begin
                n_acc   = acc_next;
                n_prod1 = {r_prod1[P1_W-CH_W-1:0], {CH_W{1'b0}}};
                if (r_cnt == '0) begin
                    n_quo   = DIV_W'(acc_next[ACC_W-1:pidfd_pkg::TIME_SHIFT]);
                    n_rem   = '0;
                    n_cnt   = CNT_W'(DIV_CYC - 1);
                    n_state = pidfd_pkg::S_DIV;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = pidfd_pkg::S_CMUL;
                end
            end
            pidfd_pkg::S_DIV: begin
                n_quo = div_quo;
                n_rem = div_rem;
                if (r_cnt == '0) begin
                    n_state = pidfd_pkg::S_ISUM;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            pidfd_pkg::S_ISUM: begin
                n_isum  = IS_W'(r_integ) + inc_use;
                n_state = pidfd_pkg::S_ICLAMP;
            end
            pidfd_pkg::S_ICLAMP: begin
                n_integ = int_clamped[LIM_W-1:0];
                n_state = pidfd_pkg::S_YSUM;
            end
            pidfd_pkg::S_YSUM: begin
                n_ysum  = r_pterm + Y_W'(r_integ) - r_dterm;
                n_state = pidfd_pkg::S_YCLAMP;
            end
            pidfd_pkg::S_YCLAMP: begin
                // Wait here while the previous word is still unread.
                if (!r_out_valid || i_ready) begin
                    n_out       = y_clamped[SB-1:0];
                    n_out_valid = 1'b1;
                    n_state     = pidfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pidfd_pkg::S_IDLE;
            end
        endcase
    end

    // State register and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidfd_pkg::S_IDLE;
            r_integ     <= '0;
            r_fd        <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_integ     <= n_integ;
            r_fd        <= n_fd;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_err   <= n_err;
        r_raw   <= n_raw;
        r_aerr  <= n_aerr;
        r_neg   <= n_neg;
        r_lock  <= n_lock;
        r_el    <= n_el;
        r_mul   <= n_mul;
        r_facc  <= n_facc;
        r_pterm <= n_pterm;
        r_dterm <= n_dterm;
        r_ysum  <= n_ysum;
        r_prod1 <= n_prod1;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_isum  <= n_isum;
    end

endmodule

`default_nettype wire

[rtl/pidfd_checker.sv]
`default_nettype none

`include "assert_macros.svh"

// Port-level checks of the controller's handshakes.
module pidfd_checker #(
    parameter int SAMPLE_BITS = pidfd_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_ready,
    input wire logic                          i_action,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic signed [SAMPLE_BITS-1:0] o_control_output
);

    // A stalled output word stays put.
    `PIDFD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_control_output), "output word changed while stalled")

    // A compute word keeps the block busy in the next cycle.
    `PIDFD_ASSERT_NEXT(a_busy_after_compute, i_valid && o_ready && (i_action == pidfd_pkg::ACT_COMPUTE), !o_ready, "ready after a compute word")

    // A clear word produces no output word and leaves the block ready.
    `PIDFD_ASSERT_NEXT(a_clear_silent, i_valid && o_ready && (i_action == pidfd_pkg::ACT_CLEAR) && !o_valid, o_ready && !o_valid, "clear word produced output or busy")

    // Reset leaves the block idle with no output word.
    `PIDFD_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, o_ready && !o_valid, "block not idle after reset")

endmodule

bind pid_filtered_derivative_top pidfd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_pidfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_action         (i_action),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_control_output (o_control_output)
);

`default_nettype wire
